FILE: design/cps_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cps_pkg
// Shared types, fixed-point constants and arithmetic helpers for the
// cart-pole step engine.
// ----------------------------------------------------------------------------
package cps_pkg;

  localparam int FRAC_BITS  = 24;
  localparam int WORD_WIDTH = 32;
  localparam int CFG_W      = 31;
  localparam int STEP_W     = 10;
  localparam int IDX_W      = 3;
  localparam int CTR_W      = 6;
  localparam int UOP_W      = 4;
  localparam int DIV_STEPS  = WORD_WIDTH + 1;
  localparam int DIV_PRE    = WORD_WIDTH - FRAC_BITS;
  localparam int RED_STEPS  = 5;

  typedef logic signed [WORD_WIDTH-1:0] word_t;

  localparam logic [IDX_W-1:0] REG_X_LIMIT     = 3'd0;
  localparam logic [IDX_W-1:0] REG_ANGLE_LIMIT = 3'd1;
  localparam logic [IDX_W-1:0] REG_STEP_LIMIT  = 3'd2;
  localparam logic [IDX_W-1:0] REG_FORCE       = 3'd3;
  localparam logic [IDX_W-1:0] REG_TIME_STEP   = 3'd4;

  localparam logic OPC_LOAD = 1'b0;
  localparam logic OPC_STEP = 1'b1;

  localparam logic [CFG_W-1:0]  X_LIMIT_RST     = 31'd40265318;
  localparam logic [CFG_W-1:0]  ANGLE_LIMIT_RST = 31'd3513960;
  localparam logic [STEP_W-1:0] STEP_LIMIT_RST  = 10'd200;
  localparam logic [CFG_W-1:0]  FORCE_RST       = 31'd167772160;
  localparam logic [CFG_W-1:0]  TIME_STEP_RST   = 31'd335544;
  localparam logic [STEP_W-1:0] STEP_MAX        = '1;

  localparam longint ONE_L    = longint'(1) << FRAC_BITS;
  localparam longint K_GRAV_L = (49 * ONE_L + 5 / 2) / 5;
  localparam longint K_PML_L  = (ONE_L + 20 / 2) / 20;
  localparam longint K_ITM_L  = (10 * ONE_L + 11 / 2) / 11;
  localparam longint K_43_L   = (4 * ONE_L + 3 / 2) / 3;
  localparam longint K_MPTM_L = (ONE_L + 11 / 2) / 11;
  localparam longint K_PMTM_L = (ONE_L + 22 / 2) / 22;
  localparam longint K_HALF_L = longint'(1) << (FRAC_BITS - 1);
  localparam logic [63:0] PI_SRC = 64'h3243F6A8885A308D;
  localparam longint PI_L      = longint'((PI_SRC + (64'd1 << (59 - FRAC_BITS)))
                                          >> (60 - FRAC_BITS));
  localparam longint TWO_PI_L  = 2 * PI_L;
  localparam longint HALF_PI_L = PI_L / 2;
  localparam longint GAIN_L    = longint'((64'd652032874 + (64'd1 << (29 - FRAC_BITS)))
                                          >> (30 - FRAC_BITS));

  localparam word_t WMAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};
  localparam word_t WMIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};

  localparam logic [31:0] ATAN_Q30 [28] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
    32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
    32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
    32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
    32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
    32'h0000001F, 32'h0000000F, 32'h00000008
  };

  typedef enum logic [3:0] {
    OP_IDLE, OP_LOAD, OP_START, OP_REDUCE, OP_FOLD, OP_ROTATE, OP_SINCOS,
    OP_MUL, OP_WB, OP_DIV_INIT, OP_DIV, OP_DIV_FIN, OP_FLAGS, OP_PUBLISH
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE, S_REDUCE, S_FOLD, S_ROTATE, S_SINCOS, S_MUL, S_WB,
    S_DIV_INIT, S_DIV, S_DIV_FIN, S_FLAGS, S_PUBLISH
  } state_t;

  typedef enum logic [4:0] {
    SEL_W, SEL_SIN, SEL_COS, SEL_T, SEL_TEMP, SEL_ACCA, SEL_ACCX, SEL_V, SEL_X,
    SEL_A, SEL_DT, SEL_FORCE, SEL_K_PML, SEL_K_ITM, SEL_K_GRAV, SEL_K_MPTM,
    SEL_K_HALF, SEL_K_PMTM, SEL_K_43
  } sel_t;

  typedef enum logic [1:0] {WB_PLAIN, WB_ADD, WB_SUB} wb_t;

  typedef enum logic [3:0] {
    DST_T, DST_TEMP, DST_NUM, DST_DEN, DST_ACCX, DST_X, DST_V, DST_A, DST_W
  } dst_t;

  typedef struct packed {
    sel_t a;
    sel_t b;
    wb_t  wb;
    sel_t c;
    dst_t dst;
  } uop_t;

  typedef struct packed {
    op_t              op;
    logic [CTR_W-1:0] cnt;
    logic [UOP_W-1:0] uop;
  } cmd_t;

  localparam logic [UOP_W-1:0] UOP_DEN  = 4'd8;
  localparam logic [UOP_W-1:0] UOP_LAST = 4'd14;

  function automatic uop_t mk(input sel_t a, input sel_t b, input wb_t wb,
                              input sel_t c, input dst_t dst);
    uop_t u;
    u.a = a; u.b = b; u.wb = wb; u.c = c; u.dst = dst;
    return u;
  endfunction

  // force, torque and Euler update sequence
  function automatic uop_t get_uop(input logic [UOP_W-1:0] i);
    uop_t u;
    case (i)
      4'd0:    u = mk(SEL_W,      SEL_W,     WB_PLAIN, SEL_T,     DST_T);
      4'd1:    u = mk(SEL_K_PML,  SEL_T,     WB_PLAIN, SEL_T,     DST_T);
      4'd2:    u = mk(SEL_T,      SEL_SIN,   WB_ADD,   SEL_FORCE, DST_T);
      4'd3:    u = mk(SEL_T,      SEL_K_ITM, WB_PLAIN, SEL_T,     DST_TEMP);
      4'd4:    u = mk(SEL_K_GRAV, SEL_SIN,   WB_PLAIN, SEL_T,     DST_T);
      4'd5:    u = mk(SEL_COS,    SEL_TEMP,  WB_SUB,   SEL_T,     DST_NUM);
      4'd6:    u = mk(SEL_COS,    SEL_COS,   WB_PLAIN, SEL_T,     DST_T);
      4'd7:    u = mk(SEL_K_MPTM, SEL_T,     WB_SUB,   SEL_K_43,  DST_T);
      4'd8:    u = mk(SEL_K_HALF, SEL_T,     WB_PLAIN, SEL_T,     DST_DEN);
      4'd9:    u = mk(SEL_K_PMTM, SEL_ACCA,  WB_PLAIN, SEL_T,     DST_T);
      4'd10:   u = mk(SEL_T,      SEL_COS,   WB_SUB,   SEL_TEMP,  DST_ACCX);
      4'd11:   u = mk(SEL_DT,     SEL_V,     WB_ADD,   SEL_X,     DST_X);
      4'd12:   u = mk(SEL_DT,     SEL_ACCX,  WB_ADD,   SEL_V,     DST_V);
      4'd13:   u = mk(SEL_DT,     SEL_W,     WB_ADD,   SEL_A,     DST_A);
      4'd14:   u = mk(SEL_DT,     SEL_ACCA,  WB_ADD,   SEL_W,     DST_W);
      default: u = mk(SEL_T,      SEL_T,     WB_PLAIN, SEL_T,     DST_T);
    endcase
    return u;
  endfunction

  function automatic word_t atan_q(input logic [4:0] i);
    logic [32:0] t;
    t = {1'b0, ATAN_Q30[i]} + (33'd1 << (29 - FRAC_BITS));
    return word_t'(t >> (30 - FRAC_BITS));
  endfunction

  function automatic word_t sat_mag(input logic [2*WORD_WIDTH:0] m, input logic neg);
    logic [2*WORD_WIDTH:0] lim;
    lim = (2*WORD_WIDTH+1)'({1'b0, WMAX});
    if (neg) begin
      if (m > lim + 1'b1) return WMIN;
      return word_t'(~m[WORD_WIDTH-1:0] + 1'b1);
    end
    if (m > lim) return WMAX;
    return word_t'(m[WORD_WIDTH-1:0]);
  endfunction

  function automatic word_t sat_sum(input logic signed [WORD_WIDTH:0] s);
    if (s[WORD_WIDTH] != s[WORD_WIDTH-1]) return s[WORD_WIDTH] ? WMIN : WMAX;
    return word_t'(s[WORD_WIDTH-1:0]);
  endfunction

endpackage
`default_nettype wire

FILE: design/cart_pole_physics_step_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cart_pole_physics_step_top
// Cart-pole environment step engine in signed Q8.24.
// ----------------------------------------------------------------------------
// A load request writes the state registers when accepted, and its result is
// valid once that state has then been loaded into the result register. A step
// request's result is valid after angle reduction, the fold, 24 CORDIC
// rotations, the sine/cosine fix-up, 15 multiplies through the single shared
// 32x32 multiplier (each a multiply state then a write-back state), with the
// restoring divider (setup, 33 quotient bits at one a cycle, finish) after the
// ninth of them, then the done check and the load of the result register. A
// result that has not been taken holds the engine in its publish state until
// the output register frees. One request is in flight at a time; a finished
// result waits in the output register while the next request is accepted.
module cart_pole_physics_step_top (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_opcode,
  input  logic                      in_push_right,
  input  logic signed [31:0]        in_init_position,
  input  logic signed [31:0]        in_init_velocity,
  input  logic signed [31:0]        in_init_angle,
  input  logic signed [31:0]        in_init_angle_rate,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [31:0]        out_position,
  output logic signed [31:0]        out_velocity,
  output logic signed [31:0]        out_angle,
  output logic signed [31:0]        out_angle_rate,
  output logic                      out_done_res,
  output logic                      out_reward,
  output logic [9:0]                out_steps_taken,
  input  logic                      cfg_we,
  input  logic [2:0]                cfg_index,
  input  logic [30:0]               cfg_data
);

  cps_pkg::cmd_t cmd;

  cps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_opcode (in_opcode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  cps_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_push_right      (in_push_right),
    .in_init_position   (in_init_position),
    .in_init_velocity   (in_init_velocity),
    .in_init_angle      (in_init_angle),
    .in_init_angle_rate (in_init_angle_rate),
    .out_position       (out_position),
    .out_velocity       (out_velocity),
    .out_angle          (out_angle),
    .out_angle_rate     (out_angle_rate),
    .out_done_res       (out_done_res),
    .out_reward         (out_reward),
    .out_steps_taken    (out_steps_taken)
  );

endmodule
`default_nettype wire

FILE: design/cps_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cps_ctrl
// Sequencer for the cart-pole step engine: handshakes, angle reduction,
// CORDIC, multiply program and divider pacing.
// ----------------------------------------------------------------------------
module cps_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          in_opcode,
  output logic          out_valid,
  input  logic          out_ready,
  output cps_pkg::cmd_t cmd
);

  cps_pkg::state_t state_r, state_nxt;
  logic [cps_pkg::CTR_W-1:0] cnt_r, cnt_nxt;
  logic [cps_pkg::UOP_W-1:0] uop_r, uop_nxt;
  logic out_valid_r, out_valid_nxt;
  logic accept, publish;

  assign accept  = (state_r == cps_pkg::S_IDLE) && in_valid;
  assign publish = (state_r == cps_pkg::S_PUBLISH) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    uop_nxt   = uop_r;
    case (state_r)
      cps_pkg::S_IDLE: begin
        if (accept) begin
          if (in_opcode == cps_pkg::OPC_LOAD) begin
            state_nxt = cps_pkg::S_PUBLISH;
          end else begin
            state_nxt = cps_pkg::S_REDUCE;
            cnt_nxt   = cps_pkg::CTR_W'(cps_pkg::RED_STEPS - 1);
          end
        end
      end
      cps_pkg::S_REDUCE: begin
        if (cnt_r == '0) state_nxt = cps_pkg::S_FOLD;
        else cnt_nxt = cnt_r - 1'b1;
      end
      cps_pkg::S_FOLD: begin
        state_nxt = cps_pkg::S_ROTATE;
        cnt_nxt   = '0;
      end
      cps_pkg::S_ROTATE: begin
        if (cnt_r == cps_pkg::CTR_W'(cps_pkg::FRAC_BITS - 1)) state_nxt = cps_pkg::S_SINCOS;
        else cnt_nxt = cnt_r + 1'b1;
      end
      cps_pkg::S_SINCOS: begin
        state_nxt = cps_pkg::S_MUL;
        uop_nxt   = '0;
      end
      cps_pkg::S_MUL: state_nxt = cps_pkg::S_WB;
      cps_pkg::S_WB: begin
        if (uop_r == cps_pkg::UOP_DEN) begin
          state_nxt = cps_pkg::S_DIV_INIT;
        end else if (uop_r == cps_pkg::UOP_LAST) begin
          state_nxt = cps_pkg::S_FLAGS;
        end else begin
          state_nxt = cps_pkg::S_MUL;
          uop_nxt   = uop_r + 1'b1;
        end
      end
      cps_pkg::S_DIV_INIT: begin
        state_nxt = cps_pkg::S_DIV;
        cnt_nxt   = '0;
      end
      cps_pkg::S_DIV: begin
        if (cnt_r == cps_pkg::CTR_W'(cps_pkg::DIV_STEPS - 1)) state_nxt = cps_pkg::S_DIV_FIN;
        else cnt_nxt = cnt_r + 1'b1;
      end
      cps_pkg::S_DIV_FIN: begin
        state_nxt = cps_pkg::S_MUL;
        uop_nxt   = uop_r + 1'b1;
      end
      cps_pkg::S_FLAGS: state_nxt = cps_pkg::S_PUBLISH;
      cps_pkg::S_PUBLISH: begin
        if (publish) state_nxt = cps_pkg::S_IDLE;
      end
      default: state_nxt = cps_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (publish) out_valid_nxt = 1'b1;
  end

  always_comb begin
    cmd.cnt = cnt_r;
    cmd.uop = uop_r;
    case (state_r)
      cps_pkg::S_IDLE: begin
        if (!accept) cmd.op = cps_pkg::OP_IDLE;
        else if (in_opcode == cps_pkg::OPC_LOAD) cmd.op = cps_pkg::OP_LOAD;
        else cmd.op = cps_pkg::OP_START;
      end
      cps_pkg::S_REDUCE:   cmd.op = cps_pkg::OP_REDUCE;
      cps_pkg::S_FOLD:     cmd.op = cps_pkg::OP_FOLD;
      cps_pkg::S_ROTATE:   cmd.op = cps_pkg::OP_ROTATE;
      cps_pkg::S_SINCOS:   cmd.op = cps_pkg::OP_SINCOS;
      cps_pkg::S_MUL:      cmd.op = cps_pkg::OP_MUL;
      cps_pkg::S_WB:       cmd.op = cps_pkg::OP_WB;
      cps_pkg::S_DIV_INIT: cmd.op = cps_pkg::OP_DIV_INIT;
      cps_pkg::S_DIV:      cmd.op = cps_pkg::OP_DIV;
      cps_pkg::S_DIV_FIN:  cmd.op = cps_pkg::OP_DIV_FIN;
      cps_pkg::S_FLAGS:    cmd.op = cps_pkg::OP_FLAGS;
      cps_pkg::S_PUBLISH:  cmd.op = publish ? cps_pkg::OP_PUBLISH : cps_pkg::OP_IDLE;
      default:             cmd.op = cps_pkg::OP_IDLE;
    endcase
    in_ready  = (state_r == cps_pkg::S_IDLE);
    out_valid = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cps_pkg::S_IDLE;
      cnt_r       <= '0;
      uop_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      uop_r       <= uop_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_step_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_opcode == cps_pkg::OPC_STEP) |=> state_r == cps_pkg::S_REDUCE)
    else $error("step request did not start angle reduction");
  a_publish_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cps_pkg::S_PUBLISH && out_valid_r && !out_ready)
      |=> (state_r == cps_pkg::S_PUBLISH && out_valid_r))
    else $error("result overwritten before it was taken");
  a_uop_range: assert property (@(posedge clk) disable iff (!rst_n)
    uop_r <= cps_pkg::UOP_LAST)
    else $error("multiply program ran past its end");
`endif

endmodule
`default_nettype wire

FILE: design/cps_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cps_dp
// Datapath: state, configuration, angle reduction, CORDIC, shared
// multiplier with rounding and saturation, restoring divider, result register.
// ----------------------------------------------------------------------------
module cps_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  cps_pkg::cmd_t              cmd,
  input  logic                       cfg_we,
  input  logic [cps_pkg::IDX_W-1:0]  cfg_index,
  input  logic [cps_pkg::CFG_W-1:0]  cfg_data,
  input  logic                       in_push_right,
  input  cps_pkg::word_t             in_init_position,
  input  cps_pkg::word_t             in_init_velocity,
  input  cps_pkg::word_t             in_init_angle,
  input  cps_pkg::word_t             in_init_angle_rate,
  output cps_pkg::word_t             out_position,
  output cps_pkg::word_t             out_velocity,
  output cps_pkg::word_t             out_angle,
  output cps_pkg::word_t             out_angle_rate,
  output logic                       out_done_res,
  output logic                       out_reward,
  output logic [cps_pkg::STEP_W-1:0] out_steps_taken
);

  localparam int W = cps_pkg::WORD_WIDTH;
  localparam int F = cps_pkg::FRAC_BITS;

  cps_pkg::word_t x_r, v_r, a_r, w_r;
  logic [cps_pkg::STEP_W-1:0] steps_r, slim_r;
  logic fallen_r, done_r, rew_r, push_r;
  logic [cps_pkg::CFG_W-1:0] xlim_r, alim_r, fmag_r, dt_r;
  logic [W-1:0] red_r;
  logic thneg_r, flip_r;
  cps_pkg::word_t cx_r, cy_r, cz_r, sin_r, cos_r;
  cps_pkg::word_t t_r, temp_r, num_r, den_r, acca_r, accx_r;
  logic [2*W-1:0] prod_r;
  logic pneg_r;
  logic [W:0] drem_r, dsh_r, dq_r;
  logic dneg_r, dspec_r;
  cps_pkg::word_t o_x_r, o_v_r, o_a_r, o_w_r;
  logic o_done_r, o_rew_r;
  logic [cps_pkg::STEP_W-1:0] o_steps_r;

  cps_pkg::uop_t uop;
  cps_pkg::word_t opa, opb, opc, mq, wbv, force_v, dt_v;
  logic [W-1:0] am, bm;
  logic [2*W:0] rnd;
  logic [W-1:0] red_sub;
  logic signed [W+1:0] rr, rw, zf;
  logic fl;
  cps_pkg::word_t xs, ys, at;
  logic [W-1:0] nmag;
  logic dspec;
  logic [W:0] rs, rq;
  logic dge;
  cps_pkg::word_t div_res;
  logic signed [W:0] xe, ae, xl, al;
  logic dn;

  function automatic cps_pkg::word_t pick(input cps_pkg::sel_t s);
    case (s)
      cps_pkg::SEL_W:      return w_r;
      cps_pkg::SEL_SIN:    return sin_r;
      cps_pkg::SEL_COS:    return cos_r;
      cps_pkg::SEL_T:      return t_r;
      cps_pkg::SEL_TEMP:   return temp_r;
      cps_pkg::SEL_ACCA:   return acca_r;
      cps_pkg::SEL_ACCX:   return accx_r;
      cps_pkg::SEL_V:      return v_r;
      cps_pkg::SEL_X:      return x_r;
      cps_pkg::SEL_A:      return a_r;
      cps_pkg::SEL_DT:     return dt_v;
      cps_pkg::SEL_FORCE:  return force_v;
      cps_pkg::SEL_K_PML:  return cps_pkg::word_t'(cps_pkg::K_PML_L);
      cps_pkg::SEL_K_ITM:  return cps_pkg::word_t'(cps_pkg::K_ITM_L);
      cps_pkg::SEL_K_GRAV: return cps_pkg::word_t'(cps_pkg::K_GRAV_L);
      cps_pkg::SEL_K_MPTM: return cps_pkg::word_t'(cps_pkg::K_MPTM_L);
      cps_pkg::SEL_K_HALF: return cps_pkg::word_t'(cps_pkg::K_HALF_L);
      cps_pkg::SEL_K_PMTM: return cps_pkg::word_t'(cps_pkg::K_PMTM_L);
      cps_pkg::SEL_K_43:   return cps_pkg::word_t'(cps_pkg::K_43_L);
      default:             return t_r;
    endcase
  endfunction

  always_comb begin
    uop     = cps_pkg::get_uop(cmd.uop);
    dt_v    = cps_pkg::word_t'(dt_r);
    force_v = push_r ? cps_pkg::word_t'(fmag_r) : -cps_pkg::word_t'(fmag_r);
    opa     = pick(uop.a);
    opb     = pick(uop.b);
    opc     = pick(uop.c);
    am      = opa[W-1] ? W'(-opa) : W'(opa);
    bm      = opb[W-1] ? W'(-opb) : W'(opb);
    rnd     = {1'b0, prod_r} + ((2*W+1)'(1) << (F - 1));
    mq      = cps_pkg::sat_mag(rnd >> F, pneg_r);
    case (uop.wb)
      cps_pkg::WB_PLAIN: wbv = mq;
      cps_pkg::WB_ADD:   wbv = cps_pkg::sat_sum({opc[W-1], opc} + {mq[W-1], mq});
      cps_pkg::WB_SUB:   wbv = cps_pkg::sat_sum({opc[W-1], opc} - {mq[W-1], mq});
      default:           wbv = mq;
    endcase
  end

  // angle reduction and fold to [-pi/2, pi/2]
  always_comb begin
    red_sub = W'((W+8)'(cps_pkg::TWO_PI_L) << cmd.cnt[2:0]);
    rr = thneg_r ? -$signed((W+2)'(red_r)) : $signed((W+2)'(red_r));
    if (rr > cps_pkg::PI_L) rw = rr - (W+2)'(cps_pkg::TWO_PI_L);
    else if (rr < -cps_pkg::PI_L) rw = rr + (W+2)'(cps_pkg::TWO_PI_L);
    else rw = rr;
    fl = 1'b1;
    if (rw > cps_pkg::HALF_PI_L) zf = (W+2)'(cps_pkg::PI_L) - rw;
    else if (rw < -cps_pkg::HALF_PI_L) zf = -(W+2)'(cps_pkg::PI_L) - rw;
    else begin
      zf = rw;
      fl = 1'b0;
    end
    xs = cx_r >>> cmd.cnt[4:0];
    ys = cy_r >>> cmd.cnt[4:0];
    at = cps_pkg::atan_q(cmd.cnt[4:0]);
  end

  always_comb begin
    nmag  = num_r[W-1] ? W'(-num_r) : W'(num_r);
    dspec = den_r[W-1] || (den_r == '0) || ((nmag >> cps_pkg::DIV_PRE) >= W'(den_r));
    rs    = {drem_r[W-1:0], dsh_r[W]};
    dge   = rs >= {1'b0, den_r};
    rq    = (dq_r + 1'b1) >> 1;
    if (dspec_r) begin
      if (num_r == '0) div_res = '0;
      else div_res = num_r[W-1] ? cps_pkg::WMIN : cps_pkg::WMAX;
    end else begin
      div_res = cps_pkg::sat_mag((2*W+1)'(rq), dneg_r);
    end
  end

  always_comb begin
    xe = {x_r[W-1], x_r};
    ae = {a_r[W-1], a_r};
    xl = $signed((W+1)'(xlim_r));
    al = $signed((W+1)'(alim_r));
    dn = (xe < -xl) || (xe > xl) || (ae < -al) || (ae > al) || (steps_r > slim_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r      <= '0;
      v_r      <= '0;
      a_r      <= '0;
      w_r      <= '0;
      steps_r  <= '0;
      fallen_r <= 1'b0;
      done_r   <= 1'b0;
      rew_r    <= 1'b0;
      xlim_r   <= cps_pkg::X_LIMIT_RST;
      alim_r   <= cps_pkg::ANGLE_LIMIT_RST;
      slim_r   <= cps_pkg::STEP_LIMIT_RST;
      fmag_r   <= cps_pkg::FORCE_RST;
      dt_r     <= cps_pkg::TIME_STEP_RST;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          cps_pkg::REG_X_LIMIT:     xlim_r <= cfg_data;
          cps_pkg::REG_ANGLE_LIMIT: alim_r <= cfg_data;
          cps_pkg::REG_STEP_LIMIT:  slim_r <= cfg_data[cps_pkg::STEP_W-1:0];
          cps_pkg::REG_FORCE:       fmag_r <= cfg_data;
          cps_pkg::REG_TIME_STEP:   dt_r   <= cfg_data;
          default: ;
        endcase
      end
      case (cmd.op)
        cps_pkg::OP_LOAD: begin
          x_r      <= in_init_position;
          v_r      <= in_init_velocity;
          a_r      <= in_init_angle;
          w_r      <= in_init_angle_rate;
          steps_r  <= '0;
          fallen_r <= 1'b0;
          done_r   <= 1'b0;
          rew_r    <= 1'b0;
        end
        cps_pkg::OP_WB: begin
          case (uop.dst)
            cps_pkg::DST_X: x_r <= wbv;
            cps_pkg::DST_V: v_r <= wbv;
            cps_pkg::DST_A: a_r <= wbv;
            cps_pkg::DST_W: w_r <= wbv;
            default: ;
          endcase
        end
        cps_pkg::OP_FLAGS: begin
          done_r <= dn;
          rew_r  <= !dn;
          if (!dn || !fallen_r) begin
            if (steps_r != cps_pkg::STEP_MAX) steps_r <= steps_r + 1'b1;
          end
          if (dn) fallen_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      cps_pkg::OP_START: begin
        push_r  <= in_push_right;
        red_r   <= a_r[W-1] ? W'(-a_r) : W'(a_r);
        thneg_r <= a_r[W-1];
      end
      cps_pkg::OP_REDUCE: begin
        if (red_r >= red_sub) red_r <= red_r - red_sub;
      end
      cps_pkg::OP_FOLD: begin
        cx_r   <= cps_pkg::word_t'(cps_pkg::GAIN_L);
        cy_r   <= '0;
        cz_r   <= cps_pkg::word_t'(zf);
        flip_r <= fl;
      end
      cps_pkg::OP_ROTATE: begin
        if (!cz_r[W-1]) begin
          cx_r <= cx_r - ys;
          cy_r <= cy_r + xs;
          cz_r <= cz_r - at;
        end else begin
          cx_r <= cx_r + ys;
          cy_r <= cy_r - xs;
          cz_r <= cz_r + at;
        end
      end
      cps_pkg::OP_SINCOS: begin
        cos_r <= flip_r ? -cx_r : cx_r;
        sin_r <= cy_r;
      end
      cps_pkg::OP_MUL: begin
        prod_r <= am * bm;
        pneg_r <= opa[W-1] ^ opb[W-1];
      end
      cps_pkg::OP_WB: begin
        case (uop.dst)
          cps_pkg::DST_T:    t_r    <= wbv;
          cps_pkg::DST_TEMP: temp_r <= wbv;
          cps_pkg::DST_NUM:  num_r  <= wbv;
          cps_pkg::DST_DEN:  den_r  <= wbv;
          cps_pkg::DST_ACCX: accx_r <= wbv;
          default: ;
        endcase
      end
      cps_pkg::OP_DIV_INIT: begin
        drem_r  <= (W+1)'(nmag >> cps_pkg::DIV_PRE);
        dsh_r   <= {nmag[cps_pkg::DIV_PRE-1:0], {(F+1){1'b0}}};
        dq_r    <= '0;
        dneg_r  <= num_r[W-1];
        dspec_r <= dspec;
      end
      cps_pkg::OP_DIV: begin
        drem_r <= dge ? rs - {1'b0, den_r} : rs;
        dq_r   <= {dq_r[W-1:0], dge};
        dsh_r  <= dsh_r << 1;
      end
      cps_pkg::OP_DIV_FIN: acca_r <= div_res;
      cps_pkg::OP_PUBLISH: begin
        o_x_r     <= x_r;
        o_v_r     <= v_r;
        o_a_r     <= a_r;
        o_w_r     <= w_r;
        o_done_r  <= done_r;
        o_rew_r   <= rew_r;
        o_steps_r <= steps_r;
      end
      default: ;
    endcase
  end

  assign out_position    = o_x_r;
  assign out_velocity    = o_v_r;
  assign out_angle       = o_a_r;
  assign out_angle_rate  = o_w_r;
  assign out_done_res    = o_done_r;
  assign out_reward      = o_rew_r;
  assign out_steps_taken = o_steps_r;

endmodule
`default_nettype wire
